FILE: design/rdf_pkg.sv
// Package for the radix digit field unit: widths, table sizes and operation codes.
// Used by the interfaces and the top level.
package rdf_pkg;
   localparam int DEF_VALUE_BITS = 64;
   localparam int TABLE_DEPTH    = 63;
   localparam int ADDR_BITS      = 6;
   localparam int COUNT_BITS     = 7;
   localparam int RADIX_BITS     = 16;
   localparam int IDX_BITS       = 11;
   localparam int OP_BITS        = 4;
   localparam int FIELD_BITS     = 64;
   localparam int POS_BITS       = 8;

   localparam logic [RADIX_BITS-1:0] RESET_RADIX = 16'd10;

   typedef logic [OP_BITS-1:0] op_type;

   localparam op_type OP_POW    = 4'd0;
   localparam op_type OP_WIDTH  = 4'd1;
   localparam op_type OP_ND_MIN = 4'd2;
   localparam op_type OP_ND_MAX = 4'd3;
   localparam op_type OP_FLOOR  = 4'd4;
   localparam op_type OP_CEIL   = 4'd5;
   localparam op_type OP_LOG    = 4'd6;
   localparam op_type OP_DIGIT  = 4'd7;
   localparam op_type OP_SUB    = 4'd8;
endpackage

FILE: design/rdf_if.sv
// Channel interfaces of the radix digit field unit: request, response, radix write.
// Depends on rdf_pkg.
interface rdf_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [rdf_pkg::OP_BITS-1:0]              op;
   logic signed [rdf_pkg::FIELD_BITS-1:0]    value;
   logic signed [rdf_pkg::POS_BITS-1:0]      position;
   logic signed [rdf_pkg::POS_BITS-1:0]      length;
   modport source (output valid, op, value, position, length, input ready);
   modport sink   (input valid, op, value, position, length, output ready);
endinterface

interface rdf_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [rdf_pkg::FIELD_BITS-1:0]    result;
   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

interface rdf_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [rdf_pkg::RADIX_BITS-1:0]           radix;
   modport source (output valid, radix, input ready);
   modport sink   (input valid, radix, output ready);
endinterface

FILE: design/rdf_ram.sv
// Generic single-clock RAM, one write port, one read port, registered read data.
// No dependencies.
module rdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/rdf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle; done pulses when the last
// quotient bit is registered. No dependencies; divisor never zero here.
module rdf_div #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] num,
   input  logic [WIDTH-1:0] den,
   output logic             done,
   output logic [WIDTH-1:0] quo,
   output logic [WIDTH-1:0] rem
);
   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    den_ff, den_in;
   logic [WIDTH:0]      cand;
   logic                ge;

   assign cand = {rem_ff, quo_ff[WIDTH-1]};
   assign ge   = cand >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? WIDTH'(cand - {1'b0, den_ff}) : cand[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

FILE: design/radix_digit_field_unit.sv
// Radix digit field unit, top level. Sequential: one transaction at a time, next request
// taken in idle after the result is posted; a waiting radix write is taken first.
// A request runs a table scan, one RAM entry per cycle (skipped for a negative value),
// then read and compute; digit ops add divides (two divides, one for a run reaching
// the top digit). A waiting result stalls the post of the next one.
// Reset and each radix write rebuild the table; count entries (19 for radix ten, up to 63).
module radix_digit_field_unit #(
   parameter int VALUE_BITS = rdf_pkg::DEF_VALUE_BITS
) (
   input  logic clock,
   input  logic reset,
   rdf_req_if.sink   req_chan,
   rdf_rsp_if.source rsp_chan,
   rdf_csr_if.sink   csr_chan
);
   localparam int VB  = VALUE_BITS;
   localparam int TW  = VB - 1;
   localparam int AB  = rdf_pkg::ADDR_BITS;
   localparam int CB  = rdf_pkg::COUNT_BITS;
   localparam int IB  = rdf_pkg::IDX_BITS;
   localparam int RB  = rdf_pkg::RADIX_BITS;
   localparam int FB  = rdf_pkg::FIELD_BITS;
   localparam int PW  = TW + RB;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BUILD = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_PREP  = 4'd3;
   localparam logic [3:0] S_RDA   = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_RDW   = 4'd6;
   localparam logic [3:0] S_CALC  = 4'd7;
   localparam logic [3:0] S_DIV1  = 4'd8;
   localparam logic [3:0] S_DIV2  = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [RB-1:0]             radix_ff, radix_in;
   logic [RB-1:0]             reff;
   logic [CB-1:0]             count_ff, count_in;
   logic [CB-1:0]             k_ff, k_in;
   logic                      pend_ff, pend_in;
   logic [TW-1:0]             t_ff, t_in;
   logic [PW-1:0]             prod;
   logic                      ovf;

   rdf_pkg::op_type           op_ff, op_in;
   logic [VB-1:0]             x_ff, x_in;
   logic signed [7:0]         pos_ff, pos_in;
   logic signed [7:0]         len_ff, len_in;
   logic [CB-1:0]             w_ff, w_in;
   logic signed [IB-1:0]      p0_ff, p0_in, p2_ff, p2_in, l3_ff, l3_in, hi_ff, hi_in;
   logic [AB-1:0]             aidx_ff, aidx_in, bidx_ff, bidx_in;
   logic [TW-1:0]             ta_ff, ta_in, tb_ff, tb_in;
   logic [FB-1:0]             res_ff, res_in;
   logic                      rv_ff, rv_in;
   logic [FB-1:0]             rout_ff, rout_in;

   logic                      div_start_ff, div_start_in;
   logic [VB-1:0]             div_num_ff, div_num_in, div_den_ff, div_den_in;
   logic                      div_done;
   logic [VB-1:0]             div_quo, div_rem;

   logic                      ram_we;
   logic [AB-1:0]             ram_waddr, ram_raddr;
   logic [TW-1:0]             ram_rdata;

   // signed views for index arithmetic
   logic signed [IB-1:0]      pos_s, len_s, w_s, cnt_s, l1, p1, l2, p2, l3, pa;
   logic                      neg, xzero;
   logic                      op7_ok, op8_empty, op8_usex;

   assign reff  = (radix_ff < RB'(2)) ? RB'(2) : radix_ff;
   assign prod  = PW'(t_ff) * PW'(reff);
   assign ovf   = |prod[PW-1:TW];
   assign neg   = x_ff[VB-1];
   assign xzero = (x_ff == '0);

   assign pos_s = IB'(pos_ff);
   assign len_s = IB'(len_ff);
   assign w_s   = signed'(IB'(w_ff));
   assign cnt_s = signed'(IB'(count_ff));

   // digit position and run adjustment
   always_comb begin
      pa = pos_s[IB-1] ? (pos_s + w_s) : pos_s;
      l1 = len_s[IB-1] ? -len_s : len_s;
      p1 = len_s[IB-1] ? (pa - l1 + IB'(1)) : pa;
      l2 = p1[IB-1] ? (l1 + p1) : l1;
      p2 = p1[IB-1] ? '0 : p1;
      l3 = (p2 + l2 > w_s) ? (w_s - p2) : l2;
   end

   assign op7_ok    = !p0_ff[IB-1] && (p0_ff < w_s);
   assign op8_empty = (l3_ff <= IB'(0)) || (p2_ff >= w_s);
   assign op8_usex  = (hi_ff >= w_s);

   rdf_ram #(.WIDTH(TW), .DEPTH(rdf_pkg::TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (t_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rdf_div #(.WIDTH(VB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign ram_we    = (state_ff == S_BUILD);
   assign ram_waddr = k_ff[AB-1:0];

   always_comb begin
      unique case (state_ff)
         S_RDA:   ram_raddr = aidx_ff;
         S_RDB:   ram_raddr = bidx_ff;
         default: ram_raddr = k_ff[AB-1:0];
      endcase
   end

   assign csr_chan.ready = (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE) && !csr_chan.valid;
   assign rsp_chan.valid = rv_ff;
   assign rsp_chan.result = signed'(rout_ff);

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      t_in         = t_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      w_in         = w_ff;
      p0_in        = p0_ff;
      p2_in        = p2_ff;
      l3_in        = l3_ff;
      hi_in        = hi_ff;
      aidx_in      = aidx_ff;
      bidx_in      = bidx_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      res_in       = res_ff;
      rv_in        = rv_ff;
      rout_in      = rout_ff;
      div_start_in = 1'b0;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;

      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_chan.valid) begin
               radix_in = csr_chan.radix;
               t_in     = TW'(1);
               k_in     = '0;
               state_in = S_BUILD;
            end else if (req_chan.valid) begin
               op_in    = req_chan.op;
               x_in     = req_chan.value[VB-1:0];
               pos_in   = req_chan.position;
               len_in   = req_chan.length;
               w_in     = '0;
               k_in     = '0;
               pend_in  = 1'b0;
               state_in = req_chan.value[VB-1] ? S_PREP : S_SCAN;
            end
         end
         S_BUILD: begin
            if (ovf || (k_ff == CB'(rdf_pkg::TABLE_DEPTH - 1))) begin
               count_in = k_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               t_in = prod[TW-1:0];
               k_in = k_ff + 1'b1;
            end
         end
         S_SCAN: begin
            // read one entry per cycle, count those not above the value
            if (pend_ff && ({1'b0, ram_rdata} <= x_ff)) begin
               w_in = w_ff + 1'b1;
            end
            if (k_ff < count_ff) begin
               k_in    = k_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            p0_in = pa;
            p2_in = p2;
            l3_in = l3;
            hi_in = p2 + l3;
            bidx_in = w_ff[AB-1:0];
            unique case (op_ff)
               rdf_pkg::OP_ND_MIN: aidx_in = AB'(pos_ff - 8'sd1);
               rdf_pkg::OP_FLOOR,
               rdf_pkg::OP_CEIL:   aidx_in = AB'(w_ff - 1'b1);
               rdf_pkg::OP_DIGIT:  aidx_in = pa[AB-1:0];
               rdf_pkg::OP_SUB: begin
                  aidx_in = AB'(p2 + l3);
                  bidx_in = p2[AB-1:0];
               end
               default:            aidx_in = pos_ff[AB-1:0];
            endcase
            state_in = S_RDA;
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            ta_in    = ram_rdata;
            state_in = S_RDW;
         end
         S_RDW: begin
            tb_in    = ram_rdata;
            state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_FIN;
            res_in   = '1;
            unique case (op_ff)
               rdf_pkg::OP_POW: begin
                  if (!pos_s[IB-1] && pos_s < cnt_s) res_in = FB'(ta_ff);
               end
               rdf_pkg::OP_WIDTH: begin
                  if (!neg) res_in = FB'(w_ff);
               end
               rdf_pkg::OP_ND_MIN: begin
                  priority if (pos_s[IB-1])             res_in = '1;
                  else if (pos_s == '0)                  res_in = '0;
                  else if (pos_s - IB'(1) < cnt_s)       res_in = FB'(ta_ff);
                  else                                   res_in = '1;
               end
               rdf_pkg::OP_ND_MAX: begin
                  priority if (pos_s[IB-1])             res_in = '1;
                  else if (pos_s == '0)                  res_in = '0;
                  else if (pos_s < cnt_s)                res_in = FB'(ta_ff) - FB'(1);
                  else                                   res_in = '1;
               end
               rdf_pkg::OP_FLOOR: begin
                  if (!neg) res_in = xzero ? '0 : FB'(ta_ff);
               end
               rdf_pkg::OP_CEIL: begin
                  priority if (neg)                      res_in = '1;
                  else if (xzero)                        res_in = '0;
                  else if (x_ff == VB'(ta_ff))           res_in = FB'(x_ff);
                  else if (w_ff < count_ff)              res_in = FB'(tb_ff);
                  else                                   res_in = '1;
               end
               rdf_pkg::OP_LOG: begin
                  if (!neg && !xzero) res_in = FB'(w_ff - 1'b1);
               end
               rdf_pkg::OP_DIGIT: begin
                  priority if (neg)                      res_in = '1;
                  else if (xzero || !op7_ok)             res_in = '0;
                  else begin
                     div_start_in = 1'b1;
                     div_num_in   = x_ff;
                     div_den_in   = VB'(ta_ff);
                     state_in     = S_DIV1;
                  end
               end
               rdf_pkg::OP_SUB: begin
                  priority if (neg)                      res_in = '1;
                  else if (xzero || op8_empty)           res_in = '0;
                  else if (op8_usex) begin
                     div_start_in = 1'b1;
                     div_num_in   = x_ff;
                     div_den_in   = VB'(tb_ff);
                     state_in     = S_DIV2;
                  end else begin
                     div_start_in = 1'b1;
                     div_num_in   = x_ff;
                     div_den_in   = VB'(ta_ff);
                     state_in     = S_DIV1;
                  end
               end
               default: res_in = '1;
            endcase
         end
         S_DIV1: begin
            if (div_done) begin
               div_start_in = 1'b1;
               if (op_ff == rdf_pkg::OP_DIGIT) begin
                  div_num_in = div_quo;
                  div_den_in = VB'(reff);
               end else begin
                  div_num_in = div_rem;
                  div_den_in = VB'(tb_ff);
               end
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               res_in   = (op_ff == rdf_pkg::OP_DIGIT) ? FB'(div_rem) : FB'(div_quo);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rv_ff || rsp_chan.ready) begin
               rv_in    = 1'b1;
               rout_in  = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BUILD;
         radix_ff     <= rdf_pkg::RESET_RADIX;
         count_ff     <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         t_ff         <= TW'(1);
         rv_ff        <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         t_ff         <= t_in;
         rv_ff        <= rv_in;
         div_start_ff <= div_start_in;
      end
      op_ff      <= op_in;
      x_ff       <= x_in;
      pos_ff     <= pos_in;
      len_ff     <= len_in;
      w_ff       <= w_in;
      p0_ff      <= p0_in;
      p2_ff      <= p2_in;
      l3_ff      <= l3_in;
      hi_ff      <= hi_in;
      aidx_ff    <= aidx_in;
      bidx_ff    <= bidx_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      res_ff     <= res_in;
      rout_ff    <= rout_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
   end
endmodule
